// ===== hdl/per_node_field_moving_average_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the per-node moving average
// Shared concurrent assertion forms, reporting through $error.
// ----------------------------------------------------------------------------
`ifndef PER_NODE_FIELD_MOVING_AVERAGE_MACROS_SVH
`define PER_NODE_FIELD_MOVING_AVERAGE_MACROS_SVH

// implication checked every clock, off while in reset
`define PNMA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PNMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pnma_pkg.sv =====
// ----------------------------------------------------------------------------
// pnma_pkg
// Types and constants of the per-node moving average.
// ----------------------------------------------------------------------------
`default_nettype none
package pnma_pkg;
    localparam int NodeCount   = 1024;
    localparam int MaxWindow   = 16;
    localparam int SampleWidth = 32;
    localparam int NodeW  = $clog2(NodeCount);
    localparam int SlotW  = $clog2(MaxWindow);
    localparam int AddrW  = NodeW + SlotW;
    localparam int CntW   = $clog2(MaxWindow + 2);
    // sum of up to MaxWindow+1 samples
    localparam int SumW   = SampleWidth + $clog2(MaxWindow + 1) + 1;
    localparam int QuoW   = SumW;
    localparam int Comps  = 4;

    localparam logic [0:0] RegWindow    = 1'b0;
    localparam logic [0:0] RegPotential = 1'b1;

    typedef logic signed [SampleWidth-1:0] sample_t;
    typedef sample_t [Comps-1:0] vec_t;
    typedef logic signed [SumW-1:0] sum_t;
    typedef sum_t [Comps-1:0] sumv_t;

    typedef struct packed {
        logic           start;
        logic [CntW-1:0] divisor;
    } div_ctl_t;
endpackage
`default_nettype wire

// ===== hdl/pnma_divider.sv =====
// ----------------------------------------------------------------------------
// pnma_divider
// Restoring divide of four signed sums by one small count, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pnma_divider
    import pnma_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_ctl_t ctl,
    input  wire sumv_t    dividend,
    output logic          done,
    output vec_t          quotient
);
    localparam int StepW = $clog2(QuoW + 1);

    logic [QuoW-1:0]  mag_reg     [Comps];
    logic [CntW:0]    rem_reg     [Comps];
    logic             neg_reg     [Comps];
    logic [CntW-1:0]  den_reg;
    logic [StepW-1:0] step_reg;
    logic             busy_reg;
    logic             done_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                step_reg <= StepW'(QuoW);
            end
            else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == StepW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (ctl.start) begin
            den_reg <= ctl.divisor;
            for (int c = 0; c < Comps; c++) begin
                neg_reg[c] <= dividend[c][SumW-1];
                mag_reg[c] <= dividend[c][SumW-1] ? QuoW'(-dividend[c])
                                                  : QuoW'(dividend[c]);
                rem_reg[c] <= '0;
            end
        end
        else if (busy_reg) begin
            for (int c = 0; c < Comps; c++) begin
                logic [CntW:0] trial;
                trial = {rem_reg[c][CntW-1:0], mag_reg[c][QuoW-1]};
                if (trial >= {1'b0, den_reg}) begin
                    rem_reg[c] <= trial - {1'b0, den_reg};
                    mag_reg[c] <= {mag_reg[c][QuoW-2:0], 1'b1};
                end
                else begin
                    rem_reg[c] <= trial;
                    mag_reg[c] <= {mag_reg[c][QuoW-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < Comps; c++) begin
            quotient[c] = neg_reg[c] ? sample_t'(-mag_reg[c][SampleWidth-1:0])
                                     : sample_t'(mag_reg[c][SampleWidth-1:0]);
        end
    end
    assign done = done_reg;
endmodule
`default_nettype wire

// ===== hdl/per_node_field_moving_average.sv =====
// ----------------------------------------------------------------------------
// per_node_field_moving_average
// Per-node sliding average of a field vector and potential over a history RAM.
// ----------------------------------------------------------------------------
// channel   dir  word contents
// s_axis    in   node, iteration, x, y, z, potential
// m_axis    out  node, avg x/y/z/potential, samples used
// cfg       in   window_width (0), potential_enable (1)
//
// One word at a time. Each history slot is read (S_READ) then summed and
// shifted (S_ACC); slots = stored, plus the top slot during warm-up, none
// at window zero. The divider then runs (start, a step per quotient bit,
// done) and the output register is loaded. The history RAM has no reset;
// the user must ensure entries are only read after being written (unchecked).
// Output is held in a register; the next word is taken once it is loaded.
// ----------------------------------------------------------------------------
`default_nettype none
`include "per_node_field_moving_average_macros.svh"
module per_node_field_moving_average
    import pnma_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // node[9:0], iteration[25:10], x[57:26], y[89:58], z[121:90], pot[153:122]
    input  wire logic [159:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // node[9:0], x[41:10], y[73:42], z[105:74], pot[137:106], used[142:138]
    output logic [143:0]      m_axis_tdata,
    input  wire logic         cfg_we,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [4:0]   cfg_data
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_ACC   = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [4:0] window_reg;
    logic       pot_en_reg;

    // history RAM, one word per node and slot
    logic [Comps*SampleWidth-1:0] hist_mem [NodeCount*MaxWindow];
    logic [Comps*SampleWidth-1:0] rd_data_reg;
    logic [AddrW-1:0]             rd_addr, wr_addr;
    logic                         rd_en, wr_en;
    logic [Comps*SampleWidth-1:0] wr_data;

    logic [NodeW-1:0] node_reg;
    logic [CntW-1:0]  used_reg;
    logic [CntW-1:0]  stored_reg;
    logic [CntW-1:0]  slot_reg;     // slot under read
    logic             has_top_reg;  // a slot "stored" receives shift
    vec_t             fresh_reg;
    vec_t             prev_reg;     // last word read, shifts one place down
    sumv_t            sum_reg;
    logic             pot_on_reg;

    div_ctl_t div_ctl;
    logic     div_go_reg;           // divider start, registered as S_DIV is entered
    logic     div_done;
    vec_t     quo;

    logic             out_valid_reg;
    logic [143:0]     out_data_reg;

    logic [4:0]       w_sat;
    logic [15:0]      iter_in;
    logic             accept;

    assign w_sat   = (window_reg > 5'(MaxWindow)) ? 5'(MaxWindow) : window_reg;
    assign iter_in = (s_axis_tdata[25:10] == 16'd0) ? 16'd1 : s_axis_tdata[25:10];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept  = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            window_reg <= 5'd10;
            pot_en_reg <= 1'b1;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                RegWindow:    window_reg <= cfg_data;
                RegPotential: pot_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // read slot slot_reg; its data arrives next cycle in S_ACC
    assign rd_en   = (state_reg == S_READ);
    assign rd_addr = {node_reg, slot_reg[SlotW-1:0]};

    always_ff @(posedge clk) begin
        if (rd_en) rd_data_reg <= hist_mem[rd_addr];
        if (wr_en) hist_mem[wr_addr] <= wr_data;
    end

    // merge: with potential off, keep the stored potential
    vec_t wr_vec;
    logic [CntW-1:0] wr_slot;
    always_comb begin
        wr_en   = 1'b0;
        wr_slot = '0;
        wr_vec  = prev_reg;
        if (state_reg == S_ACC) begin
            // write slot_reg with the word that was in slot_reg-1 (or fresh)
            wr_en   = 1'b1;
            wr_slot = slot_reg;
            wr_vec  = (slot_reg == '0) ? fresh_reg : prev_reg;
            if (!pot_on_reg) wr_vec[3] = rd_data_reg[4*SampleWidth-1 -: SampleWidth];
            if (slot_reg == stored_reg && !has_top_reg) wr_en = 1'b0;
        end
        wr_addr = {node_reg, wr_slot[SlotW-1:0]};
        wr_data = wr_vec;
    end

    // the top slot (slot_reg == stored_reg) is read too during warm-up, so the
    // potential merge sees real data there; its value is not added to the sum
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) state_reg <= S_IDLE;
        else        state_reg <= state_next;
    end

    logic last_slot;
    assign last_slot = (slot_reg == stored_reg) ||
                       (slot_reg == stored_reg - 1'b1 && !has_top_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = (w_sat == 5'd0) ? S_DIV : S_READ;
            S_READ:  state_next = S_ACC;
            S_ACC:   state_next = last_slot ? S_DIV : S_READ;
            S_DIV:   if (div_done) state_next = S_OUT;
            S_OUT:   if (!out_valid_reg || m_axis_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // start is registered so the divider sees the final sum
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) div_go_reg <= 1'b0;
        else        div_go_reg <= (state_reg != S_DIV) && (state_next == S_DIV);
    end

    assign div_ctl.start   = div_go_reg;
    assign div_ctl.divisor = used_reg;

    always_ff @(posedge clk) begin
        if (accept) begin
            logic [15:0] w16;
            w16 = {11'd0, w_sat};
            node_reg   <= s_axis_tdata[9:0];
            pot_on_reg <= pot_en_reg;
            slot_reg   <= '0;
            for (int c = 0; c < Comps; c++) begin
                fresh_reg[c] <= s_axis_tdata[26 + 32*c +: 32];
                sum_reg[c]   <= SumW'(sample_t'(s_axis_tdata[26 + 32*c +: 32]));
            end
            if (iter_in <= w16) begin
                used_reg    <= CntW'(iter_in);
                stored_reg  <= CntW'(iter_in - 16'd1);
                has_top_reg <= 1'b1;
            end
            else begin
                used_reg    <= CntW'(w_sat) + 1'b1;
                stored_reg  <= CntW'(w_sat);
                has_top_reg <= 1'b0;
            end
        end
        else if (state_reg == S_ACC) begin
            for (int c = 0; c < Comps; c++) begin
                prev_reg[c] <= rd_data_reg[SampleWidth*c +: SampleWidth];
                if (slot_reg < stored_reg && (c < 3 || pot_on_reg))
                    sum_reg[c] <= sum_reg[c] +
                                  SumW'(sample_t'(rd_data_reg[SampleWidth*c +: SampleWidth]));
            end
            slot_reg <= slot_reg + 1'b1;
        end
    end

    pnma_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (sum_reg),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) out_valid_reg <= 1'b0;
        else if (state_reg == S_OUT && (!out_valid_reg || m_axis_tready))
            out_valid_reg <= 1'b1;
        else if (m_axis_tready) out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk) begin
        if (state_reg == S_OUT && (!out_valid_reg || m_axis_tready))
            out_data_reg <= {1'b0, used_reg, (pot_on_reg ? quo[3] : sample_t'(0)),
                             quo[2], quo[1], quo[0], node_reg};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `PNMA_ASSERT_IMP(a_ready_idle, s_axis_tready, state_reg == S_IDLE, "ready outside idle")
    `PNMA_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output dropped")
    `PNMA_ASSERT_IMP(a_used, m_axis_tvalid, m_axis_tdata[142:138] != 5'd0, "zero divisor")
endmodule
`default_nettype wire

// ===== verif/tb_per_node_field_moving_average.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_node_field_moving_average
// Self-checking bench: drives sample words through the stream port, predicts
// each per-node average with its own history copy, or takes the typed word of
// a directed row, and compares each output word in order. It runs a directed
// table, then random phases across several window and potential settings.
// ----------------------------------------------------------------------------
module tb_per_node_field_moving_average
    import pnma_pkg::*;
();

    localparam int Nodes      = 1024;
    localparam int HistDepth  = 16;
    localparam int CycleLimit = 1000000;
    localparam int DrainWait  = 100;   // longer than the worst item period

    // one output word, unpacked
    typedef struct {
        logic [9:0]  node;
        logic [31:0] avg [4];
        logic [4:0]  used;
    } avg_word_t;

    // one row of the directed table
    typedef struct {
        logic [9:0]  node;
        logic [15:0] iter;
        logic [31:0] smp [4];
        bit          typed;   // expected word typed in below
        logic [31:0] exp_avg [4];
        logic [4:0]  exp_used;
    } row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // node[9:0], iteration[25:10], x[57:26], y[89:58], z[121:90], pot[153:122]
    logic [159:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // node[9:0], x[41:10], y[73:42], z[105:74], pot[137:106], used[142:138]
    logic [143:0] m_axis_tdata;
    logic         cfg_we = 1'b0;
    logic [0:0]   cfg_index = RegWindow;
    logic [4:0]   cfg_data = '0;

    per_node_field_moving_average i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // ---- predictor state ----
    int        node_hist [Nodes][HistDepth][4];
    int        field_depth [Nodes];   // written slots, field components
    int        pot_depth [Nodes];     // written slots, potential
    logic [4:0] win_reg = 5'd10;
    bit        pot_en = 1'b1;

    avg_word_t pending_avgs [$];
    int        errors = 0;
    int        mismatches = 0;
    int        cycles = 0;

    // idle control
    bit        idle_off = 1'b0;       // long stretch with no idling
    int        hold_cycles = 0;       // receiver hold-off request

    // Predict one average and shift the node history.
    task automatic compute_average(input logic [9:0] nd, input logic [15:0] it_raw,
                                   input logic [31:0] smp [4], output avg_word_t res);
        int     w;
        int     it;
        int     used;
        int     stored;
        int     nw;
        int     comps;
        longint acc;
        longint q;
        w = (win_reg > HistDepth) ? HistDepth : int'(win_reg);
        it = (it_raw == 0) ? 1 : int'(it_raw);   // iteration zero acts as one
        comps = pot_en ? 4 : 3;
        if (it <= w)
        begin
            used = it;
            stored = it - 1;
            nw = it;
        end
        else
        begin
            used = w + 1;
            stored = w;
            nw = w;
        end
        res.node = nd;
        res.used = used[4:0];
        for (int c = 0; c < 4; c++)
        begin
            acc = longint'($signed(smp[c]));
            if (c < comps)
                for (int i = 0; i < stored; i++)
                    acc += longint'(node_hist[nd][i][c]);
            q = (c < comps) ? acc / longint'(used) : 0;   // truncates toward zero
            res.avg[c] = q[31:0];
        end
        for (int j = nw - 1; j >= 0; j--)
            for (int c = 0; c < comps; c++)
                node_hist[nd][j][c] = (j == 0) ? int'($signed(smp[c])) : node_hist[nd][j-1][c];
        if (nw > field_depth[nd])
            field_depth[nd] = nw;
        if (pot_en && nw > pot_depth[nd])
            pot_depth[nd] = nw;
    endtask

    // Offer one word, wait for accept. Prediction is taken at the accept.
    task automatic send_sample(input logic [9:0] nd, input logic [15:0] it,
                               input logic [31:0] smp [4], input bit typed,
                               input avg_word_t typed_res);
        avg_word_t res;
        bit        acc;
        while (!idle_off && $urandom_range(99) < 29)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, smp[3], smp[2], smp[1], smp[0], it, nd};
        do
        begin
            @(negedge clk);
            acc = s_axis_tready;
            @(posedge clk);
        end while (!acc);
        compute_average(nd, it, smp, res);
        pending_avgs.insert(pending_avgs.size(), typed ? typed_res : res);
    endtask

    // Highest history depth readable for a node under current settings.
    function automatic int usable_depth(input logic [9:0] nd);
        if (pot_en)
            return (field_depth[nd] < pot_depth[nd]) ? field_depth[nd] : pot_depth[nd];
        return field_depth[nd];
    endfunction

    // Pick an iteration that never adds an unwritten slot into a sum.
    function automatic logic [15:0] pick_iter(input logic [9:0] nd);
        int d;
        int w;
        d = usable_depth(nd);
        w = (win_reg > HistDepth) ? HistDepth : int'(win_reg);
        if (d >= w)
        begin
            if ($urandom_range(99) < 50)
                return 16'($urandom);
            return 16'($urandom_range(d + 1, 0));
        end
        if ($urandom_range(99) < 75)
            return 16'(d + 1);             // next pass of a well-formed sequence
        return 16'($urandom_range(d + 1, 0));
    endfunction

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_avgs.size() != 0)
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);
    endtask

    // Register writes happen only with the block drained.
    task automatic write_reg(input logic [0:0] idx, input logic [4:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == RegWindow)
            win_reg = val;
        else
            pot_en = val[0];
    endtask

    task automatic random_items(input int count, input bit wide_nodes);
        logic [9:0]  nd;
        logic [15:0] it;
        logic [31:0] smp [4];
        avg_word_t   none;
        for (int n = 0; n < count; n++)
        begin
            // mostly a small pool so histories fill and sequences run deep
            if (wide_nodes || $urandom_range(99) < 15)
                nd = 10'($urandom);
            else
                nd = 10'($urandom_range(11, 0));
            it = pick_iter(nd);
            for (int c = 0; c < 4; c++)
                smp[c] = (c == 3 && $urandom_range(99) < 10) ? 32'h8000_0000 : $urandom;
            send_sample(nd, it, smp, 1'b0, none);
        end
    endtask

    // ---- receiver ready: random idling, optional long hold-off ----
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            m_axis_tready <= idle_off ? 1'b1 : ($urandom_range(99) >= 29);
    end

    // ---- output checker: sampled mid-cycle, the word moves at the next edge ----
    always @(negedge clk)
    begin
        avg_word_t e;
        avg_word_t a;
        bit        bad;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            a.node   = m_axis_tdata[9:0];
            a.avg[0] = m_axis_tdata[41:10];
            a.avg[1] = m_axis_tdata[73:42];
            a.avg[2] = m_axis_tdata[105:74];
            a.avg[3] = m_axis_tdata[137:106];
            a.used   = m_axis_tdata[142:138];
            if (pending_avgs.size() == 0)
            begin
                errors++;
                $display("ERROR: unexpected output word node=%0d", a.node);
            end
            else
            begin
                e = pending_avgs.pop_front();
                bad = (a.node !== e.node) || (a.used !== e.used);
                for (int c = 0; c < 4; c++)
                    bad |= (a.avg[c] !== e.avg[c]);
                if (bad)
                begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("MISMATCH node exp %0d got %0d | x %h/%h y %h/%h z %h/%h p %h/%h | used %0d/%0d",
                                 e.node, a.node, e.avg[0], a.avg[0], e.avg[1], a.avg[1],
                                 e.avg[2], a.avg[2], e.avg[3], a.avg[3], e.used, a.used);
                end
            end
        end
    end

    // ---- watchdog ----
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---- directed table (reset settings: window 10, potential on) ----
    row_t dir_rows [];

    initial
    begin
        avg_word_t typed_res;
        logic [31:0] mx [4];
        logic [31:0] mn [4];
        logic [31:0] zr [4];
        logic [31:0] mix [4];
        for (int c = 0; c < 4; c++)
        begin
            mx[c] = 32'h7fff_ffff;
            mn[c] = 32'h8000_0000;
            zr[c] = 32'h0;
            mix[c] = 32'h0001_8000 * (c + 1);
        end
        dir_rows = new[12];
        // first pass of a node: average is the sample itself
        dir_rows[0] = '{10'd0,    16'd1, mx,  1'b1, mx, 5'd1};
        dir_rows[1] = '{10'd1023, 16'd1, mn,  1'b1, mn, 5'd1};
        dir_rows[2] = '{10'd5,    16'd1, zr,  1'b1, zr, 5'd1};
        // iteration zero behaves like iteration one
        dir_rows[3] = '{10'd6,    16'd0, mix, 1'b1, mix, 5'd1};
        // warm-up on node 0 with extremes, then sums of both signs
        dir_rows[4] = '{10'd0,    16'd2, mx,  1'b0, zr, 5'd0};
        dir_rows[5] = '{10'd0,    16'd3, mn,  1'b0, zr, 5'd0};
        dir_rows[6] = '{10'd0,    16'd4, mix, 1'b0, zr, 5'd0};
        dir_rows[7] = '{10'd1023, 16'd2, mn,  1'b0, zr, 5'd0};
        dir_rows[8] = '{10'd1023, 16'd3, mx,  1'b0, zr, 5'd0};
        dir_rows[9] = '{10'd6,    16'd2, mn,  1'b0, zr, 5'd0};
        dir_rows[10] = '{10'd6,   16'd1, mx,  1'b0, zr, 5'd0};
        dir_rows[11] = '{10'd5,   16'd2, mix, 1'b0, zr, 5'd0};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            typed_res.node = dir_rows[r].node;
            typed_res.used = dir_rows[r].exp_used;
            typed_res.avg  = dir_rows[r].exp_avg;
            send_sample(dir_rows[r].node, dir_rows[r].iter, dir_rows[r].smp,
                        dir_rows[r].typed, typed_res);
        end
        // drive node 0 into steady state under window 10
        for (int k = 5; k <= 14; k++)
            send_sample(10'd0, 16'(k), (k[0] ? mn : mx), 1'b0, typed_res);
        send_sample(10'd0, 16'hffff, mx, 1'b0, typed_res);

        // ---- random phases across settings ----
        random_items(200, 1'b0);

        // sender waits for everything to come back, then receiver holds off
        drain();
        hold_cycles = 400;
        random_items(30, 1'b0);

        write_reg(RegWindow, 5'd0);          // window zero: sample passes through
        random_items(120, 1'b1);
        write_reg(RegWindow, 5'd16);         // widest window
        random_items(250, 1'b0);
        write_reg(RegPotential, 1'b0);
        write_reg(RegWindow, 5'd31);         // saturates to the maximum
        random_items(200, 1'b0);
        write_reg(RegWindow, 5'd3);
        random_items(150, 1'b0);
        write_reg(RegPotential, 1'b1);
        write_reg(RegWindow, 5'd1);
        idle_off = 1'b1;                     // back-to-back stretch
        random_items(150, 1'b0);
        idle_off = 1'b0;
        write_reg(RegWindow, 5'd10);
        random_items(250, 1'b0);

        drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/pnma_pkg.sv
hdl/pnma_divider.sv
hdl/per_node_field_moving_average.sv
verif/tb_per_node_field_moving_average.sv
